### rtl/core/rbht_pkg.sv
// rbht_pkg: shared types and codes of the reference-counted buffer handle table
// depends on nothing; every other file but rbht_ram refers to it by scoped names
package rbht_pkg;

    // widest slot index that any configuration of the table may need
    localparam int SLOT_IDX_BITS = 12;

    // operation codes
    localparam logic [2:0] KIND_ALLOC   = 3'd0;
    localparam logic [2:0] KIND_OPEN    = 3'd1;
    localparam logic [2:0] KIND_RELEASE = 3'd2;
    localparam logic [2:0] KIND_DEREF   = 3'd3;
    localparam logic [2:0] KIND_WAIT    = 3'd4;
    localparam logic [2:0] KIND_ADDREF  = 3'd5;

    // error codes
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_NONE_FREE = 3'd1;
    localparam logic [2:0] ERR_NOT_AWAIT = 3'd2;
    localparam logic [2:0] ERR_NOT_REL   = 3'd3;
    localparam logic [2:0] ERR_UNDER     = 3'd4;
    localparam logic [2:0] ERR_OVER      = 3'd5;
    localparam logic [2:0] ERR_ZERO      = 3'd6;

    // handle status
    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_AWAIT = 2'd1,
        ST_OPEN  = 2'd2,
        ST_REL   = 2'd3
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    // request transaction
    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] handle;
    } t_req;

    // result transaction
    typedef struct packed {
        logic [5:0]  result_handle;
        logic [1:0]  status_after;
        logic [15:0] ref_count;
        logic        became_free;
        logic [2:0]  error;
    } t_rsp;

    // free map update from the controller
    typedef struct packed {
        logic                     set;
        logic                     clr;
        logic [SLOT_IDX_BITS-1:0] slot;
    } t_fm_upd;

endpackage

### rtl/core/rbht_ram.sv
// rbht_ram: single write port, single read port synchronous memory
// registered read data; no package dependency
module rbht_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 18
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/rbht_free_map.sv
// rbht_free_map: one free bit per slot and a lowest-free search over one 64-bit word
// depends on rbht_pkg for the update struct
module rbht_free_map #(
    parameter int SLOTS = 64,
    parameter int WORDS = (SLOTS + 63) / 64,
    parameter int WB    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rbht_pkg::t_fm_upd i_upd,
    input  logic [WB-1:0]    i_word,
    output logic             o_hit,
    output logic [5:0]       o_bit
);

    localparam int MAP_BITS = WORDS * 64;
    localparam int MW       = $clog2(MAP_BITS);

    logic [MAP_BITS-1:0] r_map;
    logic [MW-1:0]       upd_idx;
    logic [63:0]         word;

    assign upd_idx = i_upd.slot[MW-1:0];

    // free bits: slot zero and padding never free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAP_BITS; i++) begin
                r_map[i] <= (i != 0) && (i < SLOTS);
            end
        end else begin
            if (i_upd.set) begin
                r_map[upd_idx] <= 1'b1;
            end
            if (i_upd.clr) begin
                r_map[upd_idx] <= 1'b0;
            end
        end
    end

    // lowest set bit of the selected word
    assign word = r_map[i_word * 64 +: 64];

    always_comb begin
        o_hit = |word;
        o_bit = '0;
        for (int i = 63; i >= 0; i--) begin
            if (word[i]) begin
                o_bit = 6'(i);
            end
        end
    end

endmodule

### rtl/core/refcounted_buffer_handle_table.sv
// refcounted_buffer_handle_table: top level, controller and per-handle update logic
// depends on rbht_pkg, rbht_ram and rbht_free_map
//
// Usage
//   Request channel: drive i_req (kind, handle) with start high; the transaction
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: exactly one result per request, shown on o_rsp for one cycle
//   with o_strobe high. The receiver cannot stall; it must take it then.
// Sequencing
//   Open, release, dereference, wait check and add reference: the entry memory
//   is read at acceptance; in the execute state the entry is modified and, where
//   it changes, written back, and the result is registered. Busy drops in the
//   same cycle as the result strobe, so no new transaction is taken before it.
//   Allocate: the free map is searched one 64-slot word per cycle, from word
//   zero up, scanning at most ceil(SLOTS/64) words.
// Reset
//   i_rst_n is synchronous, active low. After it a clearing pass writes every
//   entry of the memory, one per cycle; busy is high meanwhile.
module refcounted_buffer_handle_table #(
    parameter int SLOTS      = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  rbht_pkg::t_req i_req,
    output logic           o_strobe,
    output rbht_pkg::t_rsp o_rsp
);

    localparam int AW    = $clog2(SLOTS);
    localparam int WORDS = (SLOTS + 63) / 64;
    localparam int WB    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int EW    = 2 + COUNT_BITS;
    localparam int IB    = rbht_pkg::SLOT_IDX_BITS;

    localparam logic [AW-1:0]         LAST_SLOT = AW'(SLOTS - 1);
    localparam logic [WB-1:0]         LAST_WORD = WB'(WORDS - 1);
    localparam logic [IB:0]           SLOTS_L   = (IB + 1)'(SLOTS);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

    rbht_pkg::t_state r_state, n_state;
    rbht_pkg::t_req   r_req, n_req;
    rbht_pkg::t_rsp   r_rsp, n_rsp;
    logic             r_strobe, n_strobe;
    logic [WB-1:0]    r_word, n_word;
    logic [AW-1:0]    r_clr, n_clr;

    logic              accept;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [EW-1:0]     mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [EW-1:0]     mem_rdata;
    rbht_pkg::t_fm_upd fm_upd;
    logic              fm_hit;
    logic [5:0]        fm_bit;

    logic [IB-1:0]         in_h_ext;
    logic [IB-1:0]         req_h_ext;
    logic [WB+5:0]         found_full;
    logic [AW-1:0]         found_slot;
    logic [IB-1:0]         found_ext;
    logic                  h_valid;
    rbht_pkg::t_status     rd_st;
    logic [COUNT_BITS-1:0] rd_cnt;

    // exec results
    rbht_pkg::t_status     x_st;
    logic [COUNT_BITS-1:0] x_cnt;
    logic [2:0]            x_err;
    logic                  x_we;
    logic                  x_freed;
    logic                  x_setfree;
    logic [31:0]           x_cnt_wide;

    // entry memory: status and count
    rbht_ram #(
        .DEPTH (SLOTS),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // free map with lowest-free search
    rbht_free_map #(
        .SLOTS (SLOTS),
        .WORDS (WORDS),
        .WB    (WB)
    ) u_free_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (fm_upd),
        .i_word  (r_word),
        .o_hit   (fm_hit),
        .o_bit   (fm_bit)
    );

    assign busy     = (r_state != rbht_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // handle resizing and found slot
    assign in_h_ext   = IB'(i_req.handle);
    assign req_h_ext  = IB'(r_req.handle);
    assign found_full = {r_word, fm_bit};
    assign found_slot = found_full[AW-1:0];
    assign found_ext  = IB'(found_full);
    assign h_valid    = (r_req.handle != 6'd0) && ({1'b0, req_h_ext} < SLOTS_L);
    assign rd_st      = rbht_pkg::t_status'(mem_rdata[EW-1 -: 2]);
    assign rd_cnt     = mem_rdata[COUNT_BITS-1:0];

    // per-handle operation on the entry read back
    always_comb begin
        x_st      = rd_st;
        x_cnt     = rd_cnt;
        x_err     = rbht_pkg::ERR_OK;
        x_we      = 1'b0;
        x_freed   = 1'b0;
        x_setfree = 1'b0;
        case (r_req.kind)
            rbht_pkg::KIND_OPEN: begin
                if (rd_st != rbht_pkg::ST_AWAIT) begin
                    x_err = rbht_pkg::ERR_NOT_AWAIT;
                end else begin
                    x_st = rbht_pkg::ST_OPEN;
                    x_we = 1'b1;
                end
            end
            rbht_pkg::KIND_RELEASE, rbht_pkg::KIND_DEREF: begin
                if (r_req.kind == rbht_pkg::KIND_RELEASE && rd_st == rbht_pkg::ST_OPEN) begin
                    x_st = rbht_pkg::ST_REL;
                    x_we = 1'b1;
                end else if (rd_cnt == '0) begin
                    x_err = rbht_pkg::ERR_UNDER;
                end else begin
                    // drop one reference, free on the last
                    x_cnt = rd_cnt - CNT_ONE;
                    x_we  = 1'b1;
                    if (rd_cnt == CNT_ONE) begin
                        x_freed   = (rd_st != rbht_pkg::ST_FREE);
                        x_st      = rbht_pkg::ST_FREE;
                        x_setfree = 1'b1;
                    end
                end
            end
            rbht_pkg::KIND_WAIT: begin
                if (rd_st != rbht_pkg::ST_REL) begin
                    x_err = rbht_pkg::ERR_NOT_REL;
                end
            end
            rbht_pkg::KIND_ADDREF: begin
                if (rd_cnt == CNT_MAX) begin
                    x_err = rbht_pkg::ERR_OVER;
                end else begin
                    x_cnt = rd_cnt + CNT_ONE;
                    x_we  = 1'b1;
                end
            end
            default: begin
            end
        endcase
        // reserved or out-of-range handle
        if (!h_valid) begin
            x_st      = rbht_pkg::ST_FREE;
            x_cnt     = '0;
            x_err     = rbht_pkg::ERR_ZERO;
            x_we      = 1'b0;
            x_freed   = 1'b0;
            x_setfree = 1'b0;
        end
    end

    assign x_cnt_wide = 32'(x_cnt);

    // controller state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rbht_pkg::S_CLEAR;
            r_strobe <= 1'b0;
            r_word   <= '0;
            r_clr    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_word   <= n_word;
            r_clr    <= n_clr;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_rsp <= n_rsp;
    end

    // next state, memory and free map control
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_rsp     = r_rsp;
        n_strobe  = 1'b0;
        n_word    = r_word;
        n_clr     = r_clr;
        mem_we    = 1'b0;
        mem_waddr = req_h_ext[AW-1:0];
        mem_wdata = {x_st, x_cnt};
        mem_raddr = in_h_ext[AW-1:0];
        fm_upd    = '0;
        case (r_state)
            rbht_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = {rbht_pkg::ST_FREE, {COUNT_BITS{1'b0}}};
                n_clr     = r_clr + AW'(1);
                if (r_clr == LAST_SLOT) begin
                    n_state = rbht_pkg::S_IDLE;
                end
            end
            rbht_pkg::S_IDLE: begin
                if (accept) begin
                    n_req  = i_req;
                    n_word = '0;
                    if (i_req.kind == rbht_pkg::KIND_ALLOC) begin
                        n_state = rbht_pkg::S_SCAN;
                    end else begin
                        n_state = rbht_pkg::S_EXEC;
                    end
                end
            end
            rbht_pkg::S_SCAN: begin
                if (fm_hit) begin
                    // take the lowest free slot
                    mem_we      = 1'b1;
                    mem_waddr   = found_slot;
                    mem_wdata   = {rbht_pkg::ST_AWAIT, CNT_ONE};
                    fm_upd.clr  = 1'b1;
                    fm_upd.slot = found_ext;
                    n_rsp       = '{result_handle: found_full[5:0],
                                    status_after:  rbht_pkg::ST_AWAIT,
                                    ref_count:     16'd1,
                                    became_free:   1'b0,
                                    error:         rbht_pkg::ERR_OK};
                    n_strobe    = 1'b1;
                    n_state     = rbht_pkg::S_IDLE;
                end else if (r_word == LAST_WORD) begin
                    n_rsp    = '{result_handle: 6'd0,
                                 status_after:  rbht_pkg::ST_FREE,
                                 ref_count:     16'd0,
                                 became_free:   1'b0,
                                 error:         rbht_pkg::ERR_NONE_FREE};
                    n_strobe = 1'b1;
                    n_state  = rbht_pkg::S_IDLE;
                end else begin
                    n_word = r_word + WB'(1);
                end
            end
            rbht_pkg::S_EXEC: begin
                // write back the modified entry
                mem_we      = x_we;
                fm_upd.set  = x_setfree;
                fm_upd.slot = req_h_ext;
                n_rsp       = '{result_handle: r_req.handle,
                                status_after:  x_st,
                                ref_count:     x_cnt_wide[15:0],
                                became_free:   x_freed,
                                error:         x_err};
                n_strobe    = 1'b1;
                n_state     = rbht_pkg::S_IDLE;
            end
            default: begin
                n_state = rbht_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/rbht_checker.sv
// rbht_checker: port-level checks of the handle table, attached by bind
// depends on rbht_pkg and the top level refcounted_buffer_handle_table
module rbht_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input rbht_pkg::t_req i_req,
    input logic           o_strobe,
    input rbht_pkg::t_rsp o_rsp
);

    // an accepted transaction makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after an accepted transaction");

    // a result only follows a cycle of work
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without preceding work");

    // results never come in consecutive cycles
    a_strobe_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");

    // a reserved or out-of-range handle reports empty status and count
    a_zero_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.error == rbht_pkg::ERR_ZERO)
            |-> (o_rsp.status_after == rbht_pkg::ST_FREE && o_rsp.ref_count == 16'd0))
        else $error("reserved handle reported non-empty entry");

    // a freed handle is reported free and without error
    a_freed_is_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.became_free)
            |-> (o_rsp.status_after == rbht_pkg::ST_FREE && o_rsp.error == rbht_pkg::ERR_OK))
        else $error("freed handle not reported as free");

endmodule

bind refcounted_buffer_handle_table rbht_checker u_rbht_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);
